@@ design/http_request_header_parser_core_defines.svh @@
// Assertion macros used by the checker file of the header parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define HRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, constants and character tables of the HTTP request header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int MaxHeaderBytes = 8191;
    localparam int CountW = $clog2(MaxHeaderBytes + 1);

    // Request kinds
    localparam logic [2:0] KIND_INVALID = 3'd0;
    localparam logic [2:0] KIND_GET     = 3'd1;
    localparam logic [2:0] KIND_PUT     = 3'd2;
    localparam logic [2:0] KIND_DELETE  = 3'd3;
    localparam logic [2:0] KIND_OTHER   = 3'd4;

    // Byte classes sent from the front end to the back end
    typedef enum logic [1:0] {
        CLS_CHAR  = 2'd0,
        CLS_BREAK = 2'd1,
        CLS_END   = 2'd2,
        CLS_SKIP  = 2'd3
    } t_cls;

    // One queued beat: class, byte, and whether the verdict is due
    typedef struct packed {
        t_cls       cls;
        logic [7:0] ch;
        logic       last;
    } t_beat;

    localparam int KeyLen = 14;
    localparam int NumMethods = 9;

    // Method name characters, index 0 is the first character
    function automatic logic [7:0] method_char(input logic [3:0] m, input logic [3:0] p);
        logic [7:0] r;
        string s;
        r = 8'h00;
        case (m)
            4'd0: s = "GET";
            4'd1: s = "PUT";
            4'd2: s = "DELETE";
            4'd3: s = "HEAD";
            4'd4: s = "POST";
            4'd5: s = "OPTIONS";
            4'd6: s = "TRACE";
            4'd7: s = "PATCH";
            default: s = "CONNECT";
        endcase
        if (int'(p) < s.len()) begin
            r = s[int'(p)];
        end
        return r;
    endfunction

    function automatic logic [3:0] method_len(input logic [3:0] m);
        logic [3:0] r;
        case (m)
            4'd0, 4'd1: r = 4'd3;
            4'd2: r = 4'd6;
            4'd3, 4'd4: r = 4'd4;
            4'd5, 4'd8: r = 4'd7;
            4'd6, 4'd7: r = 4'd5;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_char(input logic [4:0] p);
        logic [7:0] r;
        string s;
        s = "Content-Length";
        r = 8'h00;
        if (int'(p) < KeyLen) begin
            r = s[int'(p)];
        end
        return r;
    endfunction

    function automatic logic [7:0] version_char(input logic [3:0] p);
        logic [7:0] r;
        string s;
        s = "HTTP/";
        r = 8'h00;
        if (int'(p) < 5) begin
            r = s[int'(p)];
        end
        return r;
    endfunction

endpackage

@@ design/hrp_if.sv @@
// ----------------------------------------------------------------------------
// hrp_in_if / hrp_out_if
// Valid/ready channels of the header parser.
// ----------------------------------------------------------------------------
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       last_byte;
    modport source (output valid, header_byte, last_byte, input ready);
    modport sink (input valid, header_byte, last_byte, output ready);
endinterface

interface hrp_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        request_kind;
    logic signed [31:0] body_length;
    modport source (output valid, request_kind, body_length, input ready);
    modport sink (input valid, request_kind, body_length, output ready);
endinterface

@@ design/hrp_front.sv @@
// ----------------------------------------------------------------------------
// hrp_front
// Counts bytes, detects end of text and classifies each byte.
// ----------------------------------------------------------------------------
module hrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_push,
    output hrp_pkg::t_beat o_beat,
    input  logic          i_full
);
    logic [hrp_pkg::CountW-1:0] r_count, n_count;
    logic r_ended, n_ended;
    logic fire;

    assign o_ready = !i_full;
    assign fire = i_valid && o_ready;
    assign o_push = fire;

    // Classify the byte and track the end of text
    always_comb begin
        n_count = r_count;
        n_ended = r_ended;
        o_beat.ch = i_byte;
        o_beat.last = i_last;
        o_beat.cls = hrp_pkg::CLS_SKIP;
        if (!r_ended) begin
            if (i_byte == 8'h00 || int'(r_count) >= hrp_pkg::MaxHeaderBytes) begin
                n_ended = 1'b1;
                o_beat.cls = hrp_pkg::CLS_END;
            end else begin
                n_count = r_count + 1'b1;
                o_beat.cls = (i_byte == 8'h0D || i_byte == 8'h0A) ?
                    hrp_pkg::CLS_BREAK : hrp_pkg::CLS_CHAR;
            end
        end else if (i_last) begin
            o_beat.cls = hrp_pkg::CLS_SKIP;
        end
        if (i_last) begin
            n_count = '0;
            n_ended = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ended <= 1'b0;
        end else if (fire) begin
            r_count <= n_count;
            r_ended <= n_ended;
        end
    end
endmodule

@@ design/hrp_queue.sv @@
// ----------------------------------------------------------------------------
// hrp_queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module hrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrp_pkg::t_beat i_beat,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hrp_pkg::t_beat o_beat
);
    hrp_pkg::t_beat r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_beat = r_mem[r_rp];

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

@@ design/hrp_back.sv @@
// ----------------------------------------------------------------------------
// hrp_back
// Runs the request line and header line parser and holds the verdict.
// ----------------------------------------------------------------------------
module hrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hrp_pkg::t_beat    i_beat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_kind,
    output logic signed [31:0] o_len
);
    typedef enum logic [1:0] {PH_START, PH_REQ, PH_HDR, PH_DONE} t_phase;
    localparam logic [1:0] NUM_SKIP = 2'd0, NUM_POS = 2'd1, NUM_NEG = 2'd2,
                           NUM_STOP = 2'd3;
    localparam logic [4:0] KEY_MISS = 5'd31;

    t_phase      r_ph, n_ph;
    logic [1:0]  r_ti, n_ti;
    logic [3:0]  r_tp, n_tp;
    logic [8:0]  r_mm, n_mm;
    logic        r_vok, n_vok;
    logic        r_body, n_body, r_colon, n_colon, r_clkey, n_clkey;
    logic [4:0]  r_kp, n_kp;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_sg, n_sg;
    logic [31:0] r_len, n_len;
    logic [2:0]  r_vd, n_vd;
    logic        r_ov;
    logic [2:0]  r_okind;
    logic [31:0] r_olen;
    logic        step, is_end, dig;
    logic [7:0]  c;
    logic [35:0] prod;
    logic [8:0]  keep;

    assign o_pop = i_valid && (!r_ov || i_ready);
    assign step = o_pop;
    assign c = i_beat.ch;
    assign dig = c >= 8'h30 && c <= 8'h39;
    assign prod = {4'd0, r_acc} * 36'd10 + {28'd0, c - 8'h30};
    assign o_valid = r_ov;
    assign o_kind = r_okind;
    assign o_len = r_olen;

    // Parse one byte
    always_comb begin
        n_ph = r_ph; n_ti = r_ti; n_tp = r_tp; n_mm = r_mm; n_vok = r_vok;
        n_body = r_body; n_colon = r_colon; n_clkey = r_clkey; n_kp = r_kp;
        n_acc = r_acc; n_sg = r_sg; n_len = r_len; n_vd = r_vd;
        keep = '0;
        is_end = i_beat.cls == hrp_pkg::CLS_BREAK || i_beat.cls == hrp_pkg::CLS_END;
        if (i_beat.cls == hrp_pkg::CLS_CHAR && r_ph == PH_START) n_ph = PH_REQ;
        if (i_beat.cls == hrp_pkg::CLS_CHAR && (r_ph == PH_START || r_ph == PH_REQ)) begin
            if (c == 8'h20) begin
                if (r_body) begin
                    if (r_ti == 2'd0) begin
                        for (int i = 0; i < hrp_pkg::NumMethods; i++)
                            keep[i] = hrp_pkg::method_len(4'(i)) == r_tp;
                        n_mm = r_mm & keep;
                    end else if (r_ti == 2'd2 && r_tp < 4'd8) n_vok = 1'b0;
                    if (r_ti != 2'd3) n_ti = r_ti + 2'd1;
                    n_body = 1'b0;
                end
            end else begin
                n_tp = r_body ? r_tp : 4'd0;
                if (!r_body && r_ti == 2'd2) n_vok = 1'b1;
                n_body = 1'b1;
                if (r_ti == 2'd0) begin
                    for (int i = 0; i < hrp_pkg::NumMethods; i++)
                        if (n_tp >= hrp_pkg::method_len(4'(i)) ||
                            hrp_pkg::method_char(4'(i), n_tp) != c) n_mm[i] = 1'b0;
                end else if (r_ti == 2'd2) begin
                    if (n_tp < 4'd5) begin
                        if (hrp_pkg::version_char(n_tp) != c) n_vok = 1'b0;
                    end else if (n_tp == 4'd5 || n_tp == 4'd7) begin
                        if (!dig) n_vok = 1'b0;
                    end else if (n_tp == 4'd6) begin
                        if (c != 8'h2E) n_vok = 1'b0;
                    end
                end
                if (n_tp < 4'd15) n_tp = n_tp + 4'd1;
            end
        end else if (i_beat.cls == hrp_pkg::CLS_CHAR && r_ph == PH_HDR) begin
            if (!r_colon) begin
                if (c == 8'h3A) begin
                    if (!r_body) begin
                        n_vd = hrp_pkg::KIND_INVALID; n_ph = PH_DONE;
                        n_body = 1'b0; n_colon = 1'b0; n_clkey = 1'b0;
                    end else begin
                        n_colon = 1'b1;
                        n_clkey = r_kp == 5'(hrp_pkg::KeyLen);
                        n_sg = NUM_SKIP; n_acc = '0;
                    end
                end else begin
                    n_body = 1'b1;
                    if (r_kp < 5'(hrp_pkg::KeyLen) && hrp_pkg::key_char(r_kp) == c)
                        n_kp = r_kp + 5'd1;
                    else n_kp = KEY_MISS;
                end
            end else if (r_clkey && r_sg != NUM_STOP) begin
                if (r_sg == NUM_SKIP && (c == 8'h20 || c == 8'h09 || c == 8'h0B ||
                                         c == 8'h0C)) begin
                end else if (r_sg == NUM_SKIP && c == 8'h2B) n_sg = NUM_POS;
                else if (r_sg == NUM_SKIP && c == 8'h2D) n_sg = NUM_NEG;
                else if (!dig) begin
                    if (r_sg == NUM_NEG) n_acc = 32'd0 - r_acc;
                    else if (r_acc > 32'h7FFF_FFFF) n_acc = 32'h7FFF_FFFF;
                    n_sg = NUM_STOP;
                end else begin
                    if (r_sg == NUM_SKIP) n_sg = NUM_POS;
                    n_acc = (prod > 36'h8000_0000) ? 32'h8000_0000 : prod[31:0];
                end
            end
        end
        // End of line: break, end of text, or final flagged byte without end
        if (is_end || (i_beat.last && i_beat.cls == hrp_pkg::CLS_CHAR)) begin
            if (n_ph == PH_REQ) begin
                if (n_body) begin
                    if (n_ti == 2'd0) begin
                        for (int i = 0; i < hrp_pkg::NumMethods; i++)
                            keep[i] = hrp_pkg::method_len(4'(i)) == n_tp;
                        n_mm = n_mm & keep;
                    end else if (n_ti == 2'd2 && n_tp < 4'd8) n_vok = 1'b0;
                    if (n_ti != 2'd3) n_ti = n_ti + 2'd1;
                end
                n_body = 1'b0; n_colon = 1'b0; n_clkey = 1'b0;
                if (n_ti == 2'd3 && n_vok && n_mm != '0) begin
                    if (n_mm[0]) begin n_vd = hrp_pkg::KIND_GET; n_ph = PH_HDR; end
                    else if (n_mm[1]) begin n_vd = hrp_pkg::KIND_PUT; n_ph = PH_HDR; end
                    else if (n_mm[2]) begin n_vd = hrp_pkg::KIND_DELETE; n_ph = PH_HDR; end
                    else begin n_vd = hrp_pkg::KIND_OTHER; n_ph = PH_DONE; end
                end else begin
                    n_vd = hrp_pkg::KIND_INVALID; n_ph = PH_DONE;
                end
            end else if (n_ph == PH_HDR && !(r_ph == PH_REQ)) begin
                if (n_body || n_colon) begin
                    if (!n_colon) begin
                        n_vd = hrp_pkg::KIND_INVALID; n_ph = PH_DONE;
                    end else if (n_clkey) begin
                        if (n_sg == NUM_NEG) n_len = 32'd0 - n_acc;
                        else if (n_sg != NUM_STOP && n_acc > 32'h7FFF_FFFF)
                            n_len = 32'h7FFF_FFFF;
                        else n_len = n_acc;
                    end
                end
                n_body = 1'b0; n_colon = 1'b0; n_clkey = 1'b0; n_kp = '0;
            end
        end
    end

    // Hold parse state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (step && i_beat.last)) begin
            r_ph <= PH_START; r_ti <= '0; r_tp <= '0; r_mm <= '1; r_vok <= 1'b0;
            r_body <= 1'b0; r_colon <= 1'b0; r_clkey <= 1'b0; r_kp <= '0;
            r_acc <= '0; r_sg <= NUM_SKIP; r_len <= '1; r_vd <= hrp_pkg::KIND_INVALID;
        end else if (step) begin
            r_ph <= n_ph; r_ti <= n_ti; r_tp <= n_tp; r_mm <= n_mm; r_vok <= n_vok;
            r_body <= n_body; r_colon <= n_colon; r_clkey <= n_clkey; r_kp <= n_kp;
            r_acc <= n_acc; r_sg <= n_sg; r_len <= n_len; r_vd <= n_vd;
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (step && i_beat.last) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
        if (step && i_beat.last) begin
            r_okind <= n_vd;
            r_olen <= n_len;
        end
    end
endmodule

@@ design/http_request_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// http_request_header_parser_core
// Parses an HTTP request header block, one byte per beat.
// ----------------------------------------------------------------------------
// channel | dir | fields
// in_ch   | in  | header_byte[7:0], last_byte
// out_ch  | out | request_kind[2:0], body_length[31:0] signed
// One byte is taken per cycle while the queue has room; the verdict is
// registered once the last byte has passed the queue and the back end's
// byte step, which sets the rate. Reset is synchronous and clears all
// control state. A stalled output holds the back end; the queue then fills
// and stalls the input.
module http_request_header_parser_core (
    input logic i_clk,
    input logic i_rst_n,
    hrp_in_if.sink in_ch,
    hrp_out_if.source out_ch
);
    logic push, full, pop, qv;
    hrp_pkg::t_beat fbeat, qbeat;

    hrp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_byte(in_ch.header_byte), .i_last(in_ch.last_byte), .o_push(push),
        .o_beat(fbeat), .i_full(full)
    );

    hrp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_beat(fbeat), .o_full(full),
        .i_pop(pop), .o_valid(qv), .o_beat(qbeat)
    );

    hrp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qv), .i_beat(qbeat), .o_pop(pop),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_kind(out_ch.request_kind),
        .o_len(out_ch.body_length)
    );
endmodule

@@ design/hrp_checker.sv @@
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks of the header parser.
// ----------------------------------------------------------------------------
`include "http_request_header_parser_core_defines.svh"
module hrp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        out_kind,
    input logic signed [31:0] out_len
);
    `HRP_ASSERT_SAME(a_kind_range, i_clk, i_rst_n, out_valid, out_kind <= hrp_pkg::KIND_OTHER)
    `HRP_ASSERT_SAME(a_other_len, i_clk, i_rst_n,
        out_valid && out_kind == hrp_pkg::KIND_OTHER, out_len == -32'sd1)
    `HRP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_len))
endmodule

bind http_request_header_parser_core hrp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.request_kind), .out_len(out_ch.body_length)
);
